// ===== design/lzss_flag_word_decompressor_assert.svh =====
// Assertion macros for the LZSS flag-word decompressor.
`ifndef LZSS_FLAG_WORD_DECOMPRESSOR_ASSERT_SVH
`define LZSS_FLAG_WORD_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define LZFW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define LZFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lzfw_pkg.sv =====
// Shared types and constants of the LZSS flag-word decompressor.
package lzfw_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OHB_W       = 4;
  localparam int unsigned FLAG_BITS   = 16;
  localparam int unsigned FLAG_IDX_W  = 4;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned OFFSET_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HIGH_BITS = 2'd1;

  localparam logic [OHB_W-1:0] OHB_RESET = 4'd4;
  localparam logic [OHB_W-1:0] OHB_MIN   = 4'd3;
  localparam logic [OHB_W-1:0] OHB_MAX   = 4'd8;
  localparam logic [LEN_W-1:0] MIN_MATCH = 6'd3;

  typedef enum logic [2:0] {
    ST_FLAG_LO,
    ST_FLAG_HI,
    ST_BODY,
    ST_MATCH_HI,
    ST_COPY
  } lzfw_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic flag_lo;      // hold low flag byte
    logic flag_hi;      // build flag word, restart bit index
    logic literal;      // emit input byte
    logic match_lo;     // hold low match byte
    logic match_start;  // decode match, arm copy
    logic next_flag;    // advance flag bit index
    logic copy;         // run copy engine
  } lzfw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic flag_bit;
    logic flag_last;
    logic out_free;
    logic copy_done;
  } lzfw_stat_t;

endpackage

// ===== design/lzss_flag_word_decompressor.sv =====
// Top level of the LZSS flag-word decompressor: controller, datapath and checks.
// A literal is on the output the cycle after it is accepted. A match high byte
// starts the copy engine: the decoded match, the history RAM read and the output
// are registered in turn; copied bytes then follow one per cycle while the output
// is not stalled (RAM read/write ports), and the input is held off until the copy ends.
// Reset clears control and counters at once; the history RAM is not cleared.
module lzss_flag_word_decompressor #(
  parameter int unsigned HISTORY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lzfw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lzfw_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lzfw_pkg::BYTE_W-1:0]    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lzfw_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          run_last_o,
  output logic                          stream_done_o,
  output logic                          bad_offset_o
);
  import lzfw_pkg::*;

  `include "lzss_flag_word_decompressor_assert.svh"

  lzfw_cmd_t  cmd;
  lzfw_stat_t stat;
  logic       restart;

  // Writing the stream size restarts the stream.
  assign restart = cfg_we_i && (cfg_idx_i == REG_TOTAL_SIZE);

  lzfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lzfw_dpath #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .bad_offset_o  (bad_offset_o)
  );

  // The byte that finishes the stream always ends the run of its item.
  `LZFW_ASSERT_NOW(a_done_is_last, out_valid_o && stream_done_o, run_last_o, "stream end not last")
  // A byte of a match that reaches before the stream start reads as zero.
  `LZFW_ASSERT_NOW(a_bad_is_zero, out_valid_o && bad_offset_o, out_byte_o == '0, "bad byte not zero")
  // The controller leaves the copy once its last byte is emitted.
  `LZFW_ASSERT_NEXT(a_copy_exit, cmd.copy && stat.copy_done, !cmd.copy, "copy did not end")

endmodule

// ===== design/lzfw_ctrl.sv =====
// Controller state machine: payload phase, flag walk and copy sequencing.
module lzfw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzfw_pkg::lzfw_stat_t stat_i,
  output lzfw_pkg::lzfw_cmd_t  cmd_o
);
  import lzfw_pkg::*;

  lzfw_state_e state_q, state_d;
  logic        take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FLAG_LO;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q == ST_COPY) || !stat_i.out_free;
    take       = in_valid_i && !in_stall_o && !stat_i.rem_zero;
    case (state_q)
      ST_FLAG_LO: begin
        if (take) begin
          cmd_o.flag_lo = 1'b1;
          state_d       = ST_FLAG_HI;
        end
      end
      ST_FLAG_HI: begin
        if (take) begin
          cmd_o.flag_hi = 1'b1;
          state_d       = ST_BODY;
        end
      end
      ST_BODY: begin
        if (take) begin
          if (stat_i.flag_bit) begin
            cmd_o.match_lo = 1'b1;
            state_d        = ST_MATCH_HI;
          end else begin
            cmd_o.literal   = 1'b1;
            cmd_o.next_flag = 1'b1;
            state_d         = stat_i.flag_last ? ST_FLAG_LO : ST_BODY;
          end
        end
      end
      ST_MATCH_HI: begin
        if (take) begin
          cmd_o.match_start = 1'b1;
          state_d           = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (stat_i.copy_done) begin
          cmd_o.next_flag = 1'b1;
          state_d         = stat_i.flag_last ? ST_FLAG_LO : ST_BODY;
        end
      end
      default: begin
        state_d = ST_FLAG_LO;
      end
    endcase
    // A new stream size drops whatever phase was in progress.
    if (restart_i) begin
      state_d = ST_FLAG_LO;
    end
  end

endmodule

// ===== design/lzfw_dpath.sv =====
// Datapath: flag word, stream counters, history RAM, copy engine, output register.
module lzfw_dpath #(
  parameter int unsigned HISTORY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          cfg_we_i,
  input  logic [lzfw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lzfw_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [lzfw_pkg::BYTE_W-1:0]    in_byte_i,
  input  lzfw_pkg::lzfw_cmd_t            cmd_i,
  output lzfw_pkg::lzfw_stat_t           stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [lzfw_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          run_last_o,
  output logic                          stream_done_o,
  output logic                          bad_offset_o
);
  import lzfw_pkg::*;

  localparam int unsigned HistDepth = 1 << HISTORY_BITS;

  logic [BYTE_W-1:0] mem [HistDepth];

  logic [OHB_W-1:0]        ohb_q;
  logic [CFG_W-1:0]        remaining_q;
  logic [CFG_W-1:0]        produced_q;
  logic [HISTORY_BITS-1:0] wp_q;
  logic [BYTE_W-1:0]       held_q;
  logic [FLAG_BITS-1:0]    flag_word_q;
  logic [FLAG_IDX_W-1:0]   flag_idx_q;

  logic [HISTORY_BITS-1:0] src_q;
  logic [LEN_W-1:0]        rd_left_q;
  logic [LEN_W-1:0]        wr_left_q;
  logic                    bad_q;
  logic                    pend_q;
  logic [BYTE_W-1:0]       rd_data_q;
  logic                    byp_q;
  logic [BYTE_W-1:0]       byp_data_q;

  logic                    out_valid_q;
  logic [BYTE_W-1:0]       out_byte_q;
  logic                    run_last_q;
  logic                    done_q;
  logic                    bad_out_q;

  logic [OHB_W-1:0]        hb;
  logic [BYTE_W:0]         mask9;
  logic [OFFSET_W-1:0]     offset;
  logic [LEN_W-1:0]        len_raw;
  logic [LEN_W-1:0]        len_cut;
  logic                    bad_new;
  logic                    out_free;
  logic                    fire;
  logic                    issue;
  logic                    load;
  logic [BYTE_W-1:0]       rdata;
  logic [BYTE_W-1:0]       wdata;

  // Match decode from held low byte and incoming high byte.
  always_comb begin
    hb = ohb_q;
    if (ohb_q < OHB_MIN) begin
      hb = OHB_MIN;
    end else if (ohb_q > OHB_MAX) begin
      hb = OHB_MAX;
    end
    mask9   = ({{BYTE_W{1'b0}}, 1'b1} << hb) - {{BYTE_W{1'b0}}, 1'b1};
    offset  = {1'b0, in_byte_i & mask9[BYTE_W-1:0], held_q} + OFFSET_W'(1);
    len_raw = LEN_W'(in_byte_i >> hb) + MIN_MATCH;
    len_cut = (remaining_q < CFG_W'(len_raw)) ? remaining_q[LEN_W-1:0] : len_raw;
    bad_new = (CFG_W'(offset) > produced_q);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = cmd_i.copy && pend_q && out_free;
  assign issue    = cmd_i.copy && (rd_left_q != '0) && (!pend_q || fire);
  assign load     = cmd_i.literal || fire;
  assign rdata    = byp_q ? byp_data_q : rd_data_q;
  assign wdata    = cmd_i.literal ? in_byte_i : (bad_q ? '0 : rdata);

  assign stat_o.rem_zero  = (remaining_q == '0);
  assign stat_o.flag_bit  = flag_word_q[flag_idx_q];
  assign stat_o.flag_last = (flag_idx_q == FLAG_IDX_W'(FLAG_BITS - 1));
  assign stat_o.out_free  = out_free;
  assign stat_o.copy_done = fire && (wr_left_q == LEN_W'(1));

  // History RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mem[wp_q] <= wdata;
    end
    if (issue) begin
      rd_data_q  <= mem[src_q];
      byp_data_q <= wdata;
    end
  end

  // Stream and flag state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ohb_q       <= OHB_RESET;
      remaining_q <= '0;
      produced_q  <= '0;
      wp_q        <= '0;
      held_q      <= '0;
      flag_word_q <= '0;
      flag_idx_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_OFFSET_HIGH_BITS)) begin
        ohb_q <= cfg_wdata_i[OHB_W-1:0];
      end
      if (restart_i) begin
        remaining_q <= cfg_wdata_i;
        produced_q  <= '0;
        wp_q        <= '0;
        held_q      <= '0;
        flag_word_q <= '0;
        flag_idx_q  <= '0;
      end else begin
        if (load) begin
          remaining_q <= remaining_q - CFG_W'(1);
          produced_q  <= produced_q + CFG_W'(1);
          wp_q        <= wp_q + HISTORY_BITS'(1);
        end
        if (cmd_i.flag_lo || cmd_i.match_lo) begin
          held_q <= in_byte_i;
        end
        if (cmd_i.flag_hi) begin
          flag_word_q <= {in_byte_i, held_q};
          flag_idx_q  <= '0;
        end else if (cmd_i.next_flag) begin
          flag_idx_q <= flag_idx_q + FLAG_IDX_W'(1);
        end
      end
    end
  end

  // Copy engine: read runs one byte ahead of the write; forward on address hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q     <= '0;
      rd_left_q <= '0;
      wr_left_q <= '0;
      bad_q     <= 1'b0;
      pend_q    <= 1'b0;
      byp_q     <= 1'b0;
    end else begin
      if (cmd_i.match_start) begin
        src_q     <= wp_q - offset[HISTORY_BITS-1:0];
        rd_left_q <= len_cut;
        wr_left_q <= len_cut;
        bad_q     <= bad_new;
        pend_q    <= 1'b0;
      end else begin
        if (issue) begin
          src_q     <= src_q + HISTORY_BITS'(1);
          rd_left_q <= rd_left_q - LEN_W'(1);
          pend_q    <= 1'b1;
          byp_q     <= load && (wp_q == src_q);
        end else if (fire) begin
          pend_q <= 1'b0;
        end
        if (fire) begin
          wr_left_q <= wr_left_q - LEN_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= wdata;
      run_last_q <= cmd_i.literal || (wr_left_q == LEN_W'(1));
      done_q     <= (remaining_q == CFG_W'(1));
      bad_out_q  <= fire && bad_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;
  assign bad_offset_o  = bad_out_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the LZSS flag-word decompressor: directed table, then random streams.
module tb_top;
  import lzfw_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 104;
  localparam int unsigned DIR_ROWS      = 34;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {RK_BYTE, RK_CFG} row_kind_e;

  // One decompressed byte as it leaves the block.
  typedef struct packed {
    logic [7:0] byte_v;
    logic       run_last;
    logic       stream_done;
    logic       bad_offset;
  } dec_byte_t;

  // One row of the directed table: a register write or a payload item,
  // optionally with the results typed in by hand.
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [23:0] val;
    logic        typed;
    logic [5:0]  n;
    logic [7:0]  ob;
    logic        done;
    logic        bad;
  } dir_row_t;

  localparam dir_row_t NO_ROW = '0;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        in_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic              run_last_o;
  logic              stream_done_o;
  logic              bad_offset_o;

  lzss_flag_word_decompressor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .bad_offset_o  (bad_offset_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decompressor shadow state: registers, history and stream position.
  logic [23:0]   m_total;
  logic [3:0]    m_ohb;
  logic [7:0]    m_hist [0:65535];
  logic [15:0]   m_wpos;
  logic [23:0]   m_remain;
  logic [15:0]   m_flags;
  logic [4:0]    m_fidx;
  lzfw_state_e   m_phase;
  logic [7:0]    m_held;

  dec_byte_t     step_bytes[$];     // bytes caused by the item just taken
  dec_byte_t     out_bytes_due[$];  // bytes the block still owes, oldest first
  int unsigned   errors = 0;
  int unsigned   cycles = 0;

  // Pacing and stimulus controls used by the sender, the receiver and the sequence.
  bit            calm = 1'b0;
  bit            noisy = 1'b0;
  bit            hold_req = 1'b0;
  logic [15:0]   next_flag_word;
  logic [7:0]    next_match_hi;

  function automatic int unsigned sat_ohb(input logic [3:0] v);
    if (v < OHB_MIN) return 32'(OHB_MIN);
    if (v > OHB_MAX) return 32'(OHB_MAX);
    return 32'(v);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void restart_stream();
    m_wpos  = '0;
    m_flags = '0;
    m_fidx  = 5'(FLAG_BITS);
    m_phase = ST_FLAG_LO;
    m_held  = '0;
  endfunction

  function automatic void set_reg(input logic [1:0] idx, input logic [23:0] val);
    if (idx == REG_TOTAL_SIZE) begin
      m_total  = val;
      m_remain = val;
      restart_stream();
    end else if (idx == REG_OFFSET_HIGH_BITS) begin
      m_ohb = val[3:0];
    end
  endfunction

  function automatic void put_out(input logic [7:0] v, input logic bad);
    m_hist[m_wpos] = v;
    m_wpos++;
    m_remain--;
    step_bytes.push_back('{byte_v: v, run_last: 1'b0, stream_done: (m_remain == 0),
                           bad_offset: bad});
  endfunction

  function automatic void next_flag();
    m_fidx++;
    if (m_fidx >= FLAG_BITS) begin
      m_fidx  = 5'(FLAG_BITS);
      m_phase = ST_FLAG_LO;
    end else begin
      m_phase = ST_BODY;
    end
  endfunction

  // Advance the shadow state by one payload byte; fill step_bytes.
  function automatic void decompress_byte(input logic [7:0] b);
    int unsigned hb;
    int unsigned offs;
    int unsigned len;
    int unsigned made;
    logic [15:0] src;
    logic        bad;
    step_bytes.delete();
    if (m_remain == 0) return;  // stream idle: drop the item
    case (m_phase)
      ST_FLAG_LO: begin
        m_held  = b;
        m_phase = ST_FLAG_HI;
      end
      ST_FLAG_HI: begin
        m_flags = {b, m_held};
        m_fidx  = '0;
        m_phase = ST_BODY;
      end
      ST_BODY: begin
        if (m_flags[m_fidx[3:0]]) begin
          m_held  = b;
          m_phase = ST_MATCH_HI;
        end else begin
          put_out(b, 1'b0);
          next_flag();
        end
      end
      default: begin
        hb   = sat_ohb(m_ohb);
        offs = (((b & ((1 << hb) - 1)) << 8) | m_held) + 1;
        len  = (b >> hb) + 3;
        if (len > m_remain) len = 32'(m_remain);  // cut the copy at the stream end
        made = 32'(m_total) - 32'(m_remain);
        bad  = (offs > made);
        src  = 16'(m_wpos - offs);
        // Copy one byte at a time so overlapping matches repeat.
        repeat (len) begin
          put_out(bad ? 8'h00 : m_hist[src], bad);
          src++;
        end
        next_flag();
      end
    endcase
    if (step_bytes.size() != 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
  endfunction

  // Pick the next payload byte so that the stream stays well formed.
  function automatic logic [7:0] next_payload_byte();
    int unsigned hb;
    int unsigned made;
    int unsigned reach;
    int unsigned offs;
    int unsigned len_code;
    logic [15:0] fw;
    if (noisy) return 8'($urandom);
    case (m_phase)
      ST_FLAG_LO: begin
        case ($urandom_range(0, 7))
          0:       fw = '0;
          1:       fw = '1;
          default: fw = 16'($urandom);
        endcase
        next_flag_word = fw;
        return fw[7:0];
      end
      ST_FLAG_HI:  return next_flag_word[15:8];
      ST_MATCH_HI: return next_match_hi;
      default: begin
        if (!m_flags[m_fidx[3:0]]) return 8'($urandom);
        hb    = sat_ohb(m_ohb);
        made  = 32'(m_total) - 32'(m_remain);
        reach = 1 << (hb + 8);
        if (made != 0 && $urandom_range(0, 7) != 0) begin
          // Stay inside what was produced; favor short distances.
          if (made < reach) reach = made;
          if (reach > 8 && $urandom_range(0, 1) == 0) reach = 8;
          offs = $urandom_range(1, reach);
        end else begin
          offs = $urandom_range(1, reach);
        end
        len_code      = $urandom_range(0, 255 >> hb);
        next_match_hi = 8'((len_code << hb) | ((offs - 1) >> 8));
        return 8'(offs - 1);
      end
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [23:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = RK_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] v);
    dir_row_t r;
    r      = '0;
    r.kind = RK_BYTE;
    r.val  = 24'(v);
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [7:0] v, input logic [5:0] n,
                                       input logic [7:0] ob, input logic done,
                                       input logic bad);
    dir_row_t r;
    r       = byte_row(v);
    r.typed = 1'b1;
    r.n     = n;
    r.ob    = ob;
    r.done  = done;
    r.bad   = bad;
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_reg(idx, val);
  endtask

  // Offer one item, hold it until taken, then book its results.
  task automatic send_byte(input logic [7:0] b, input dir_row_t row);
    int unsigned gap;
    int          k;
    gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decompress_byte(b);
    if (row.typed) begin
      step_bytes.delete();
      for (k = 0; k < row.n; k++)
        step_bytes.push_back('{byte_v: row.ob, run_last: (k == row.n - 1),
                               stream_done: row.done && (k == row.n - 1),
                               bad_offset: row.bad});
    end
    foreach (step_bytes[i]) out_bytes_due.push_back(step_bytes[i]);
  endtask

  // Drop valid, wait until every owed byte is out, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (out_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver pacing: alternate free runs and stalls, or hold off on request.
  initial begin : rx_pacing
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm || out_stall_i) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Compare every accepted output byte with the oldest one owed.
  always @(posedge clk_i) begin : out_check
    dec_byte_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (out_bytes_due.size() == 0) begin
        $error("unexpected output byte %0h", out_byte_o);
        errors++;
      end else begin
        want = out_bytes_due.pop_front();
        if (out_byte_o !== want.byte_v) begin
          $error("out_byte: expected %0h, got %0h", want.byte_v, out_byte_o);
          errors++;
        end
        if (run_last_o !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
          errors++;
        end
        if (stream_done_o !== want.stream_done) begin
          $error("stream_done: expected %0b, got %0b", want.stream_done, stream_done_o);
          errors++;
        end
        if (bad_offset_o !== want.bad_offset) begin
          $error("bad_offset: expected %0b, got %0b", want.bad_offset, bad_offset_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main_seq
    dir_row_t    dir_tab [DIR_ROWS];
    int unsigned nitems;
    int unsigned sn;
    int unsigned cut;
    int unsigned n;
    logic [3:0]  ohb;
    logic [23:0] total;
    logic [23:0] ohb_val;

    m_total  = '0;
    m_remain = '0;
    m_ohb    = OHB_RESET;
    restart_stream();

    dir_tab = '{
      // after reset nothing is armed: drop the item
      chk_row(8'hA5, 6'd0, 8'h00, 1'b0, 1'b0),
      cfg_row(REG_UNUSED, 24'd5),
      // all-zero flag word: plain literals up to the end of a short stream
      cfg_row(REG_TOTAL_SIZE, 24'd3),
      byte_row(8'h00), byte_row(8'h00),
      chk_row(8'h00, 6'd1, 8'h00, 1'b0, 1'b0),
      chk_row(8'hFF, 6'd1, 8'hFF, 1'b0, 1'b0),
      chk_row(8'h7E, 6'd1, 8'h7E, 1'b1, 1'b0),
      chk_row(8'h3C, 6'd0, 8'h00, 1'b0, 1'b0),
      // largest stream, fewest offset bits: overlap, longest bad match, plain match
      cfg_row(REG_OFFSET_HIGH_BITS, 24'(OHB_MIN)),
      cfg_row(REG_TOTAL_SIZE, 24'hFFFFFF),
      byte_row(8'h0E), byte_row(8'h00),
      chk_row(8'h5A, 6'd1, 8'h5A, 1'b0, 1'b0),
      byte_row(8'h00),
      chk_row(8'h00, 6'd3, 8'h5A, 1'b0, 1'b0),
      byte_row(8'hFF),
      chk_row(8'hFF, 6'd34, 8'h00, 1'b0, 1'b1),
      byte_row(8'h03), byte_row(8'h08),
      // offset bits above range saturate to eight
      cfg_row(REG_OFFSET_HIGH_BITS, 24'hF),
      cfg_row(REG_TOTAL_SIZE, 24'd5),
      byte_row(8'h02), byte_row(8'h00),
      chk_row(8'h80, 6'd1, 8'h80, 1'b0, 1'b0),
      byte_row(8'h00),
      chk_row(8'hFF, 6'd3, 8'h00, 1'b0, 1'b1),
      chk_row(8'h01, 6'd1, 8'h01, 1'b1, 1'b0),
      // offset bits below range saturate to three; match cut at the stream end
      cfg_row(REG_OFFSET_HIGH_BITS, 24'h0),
      cfg_row(REG_TOTAL_SIZE, 24'd3),
      byte_row(8'h01), byte_row(8'h00), byte_row(8'h00),
      chk_row(8'h08, 6'd3, 8'h00, 1'b1, 1'b1)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table; write registers only once idle.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == RK_CFG) begin
        wait_drained();
        write_reg(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        send_byte(dir_tab[r].val[7:0], dir_tab[r]);
      end
    end

    // Random part: one stream per pass, most well formed, some pure noise.
    nitems = 0;
    sn     = 0;
    while (nitems < RANDOM_ITEMS) begin
      wait_drained();
      calm  = (sn % 4 == 3);
      noisy = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       ohb = 4'($urandom_range(0, 15));
        1:       ohb = OHB_MIN;
        2:       ohb = OHB_MAX;
        default: ohb = 4'($urandom_range(OHB_MIN, OHB_MAX));
      endcase
      case ($urandom_range(0, 11))
        0:       total = '0;
        1:       total = 24'($urandom_range(1, 4));
        default: total = 24'($urandom_range(8, 90));
      endcase
      if (sn == 1) begin
        // Long matches against a receiver that holds off: fill the block up.
        ohb   = OHB_MIN;
        total = 24'd90;
        noisy = 1'b0;
      end
      ohb_val      = 24'($urandom);
      ohb_val[3:0] = ohb;
      write_reg(REG_OFFSET_HIGH_BITS, ohb_val);
      write_reg(REG_TOTAL_SIZE, total);
      if (sn == 1) hold_req = 1'b1;
      // Now and then restart the stream part way through.
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      n   = 0;
      while (m_remain != 0 && nitems < RANDOM_ITEMS && !(cut != 0 && n == cut)) begin
        send_byte(next_payload_byte(), NO_ROW);
        n++;
        nitems++;
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
      // A stray item after the stream has ended must vanish.
      if (m_remain == 0 && $urandom_range(0, 2) == 0) begin
        send_byte(8'($urandom), NO_ROW);
        nitems++;
      end
      sn++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lzfw_pkg.sv
design/lzfw_ctrl.sv
design/lzfw_dpath.sv
design/lzss_flag_word_decompressor.sv
verif/tb_top.sv
